### design/xume_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// xume_pkg
// Shared types and constants for the group-3 unary instruction encoder.
// -----------------------------------------------------------------------------
package xume_pkg;

	localparam int MaxBytes = 8;
	localparam int IdxW     = $clog2(MaxBytes);

	localparam logic [7:0] RexBase   = 8'h40;
	localparam logic [7:0] RexW      = 8'h08;
	localparam logic [7:0] OpcUnary  = 8'hF7;

	localparam logic [1:0] ModDirect = 2'b11;
	localparam logic [1:0] ModDisp8  = 2'b01;
	localparam logic [1:0] ModDisp32 = 2'b10;
	localparam logic [2:0] RmSib     = 3'd4;
	localparam logic [2:0] SibNoIdx  = 3'd4;

	localparam logic [IdxW-1:0] LastReg   = IdxW'(2);
	localparam logic [IdxW-1:0] LastShort = IdxW'(3);
	localparam logic [IdxW-1:0] LastLong  = IdxW'(6);

	typedef struct packed {
		logic        is_memory;
		logic [2:0]  op_extension;
		logic [3:0]  reg_number;
		logic [3:0]  base_reg;
		logic        has_index;
		logic [3:0]  index_reg;
		logic [1:0]  scale_log2;
		logic [31:0] displacement;
	} instr_t;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [IdxW-1:0]          last_idx;
	} enc_t;

endpackage
`default_nettype wire

### design/x64_unary_modrm_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// x64_unary_modrm_encoder_core
// Encodes F7 /digit instructions with 64-bit operand size into a byte stream.
// -----------------------------------------------------------------------------
//  port group  dir  tdata / tuser                          per beat
//  s_*         in   tuser: is_memory; tdata: operand item  one instruction
//  m_*         out  tdata: code_byte; tlast: last_byte     one byte
//
//  A register form gives 3 bytes, a memory form 4 to 8; each goes out one byte
//  per beat, held while m_tready is low.
//  From accept to first byte, an instruction passes the input register, then the result register.
//  The next instruction is taken while the current one is still going out.
//  Reset clears the valid flags of both registers; m_tready low holds a byte.
// -----------------------------------------------------------------------------
module x64_unary_modrm_encoder_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,  // op_extension[2:0], reg_number[6:3],
	                              // base_reg[10:7], has_index[11],
	                              // index_reg[15:12], scale_log2[17:16],
	                              // displacement[49:18], zero[55:50]
	input  wire         s_tuser,  // is_memory
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,  // code_byte[7:0]
	output logic        m_tlast   // last_byte
);

	xume_pkg::instr_t instr_s1;
	xume_pkg::enc_t   enc;
	logic             valid_s1;
	logic             enc_take;

	assign s_tready = !valid_s1 || enc_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			instr_s1.is_memory    <= s_tuser;
			instr_s1.op_extension <= s_tdata[2:0];
			instr_s1.reg_number   <= s_tdata[6:3];
			instr_s1.base_reg     <= s_tdata[10:7];
			instr_s1.has_index    <= s_tdata[11];
			instr_s1.index_reg    <= s_tdata[15:12];
			instr_s1.scale_log2   <= s_tdata[17:16];
			instr_s1.displacement <= s_tdata[49:18];
		end
	end

	xume_encode u_encode (
		.instr (instr_s1),
		.enc   (enc)
	);

	xume_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (valid_s1),
		.enc       (enc),
		.enc_take  (enc_take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

### design/xume_encode.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// xume_encode
// Builds the REX, opcode, ModRM, SIB and displacement bytes of one instruction.
// -----------------------------------------------------------------------------
module xume_encode (
	input  xume_pkg::instr_t instr,
	output xume_pkg::enc_t   enc
);

	logic       short_disp;
	logic       need_sib;
	logic [1:0] mod_code;
	logic [7:0] rex;
	logic [7:0] modrm;
	logic [7:0] sib;
	logic [3:0][7:0] disp_b;

	always_comb begin
		short_disp = (instr.displacement[31:7] == 25'd0) ||
			(instr.displacement[31:7] == {25{1'b1}});
		need_sib   = instr.has_index || (instr.base_reg[2:0] == xume_pkg::RmSib);
		mod_code   = short_disp ? xume_pkg::ModDisp8 : xume_pkg::ModDisp32;
		disp_b     = instr.displacement;
		sib        = {instr.scale_log2,
			instr.has_index ? instr.index_reg[2:0] : xume_pkg::SibNoIdx,
			instr.base_reg[2:0]};

		enc = '0;
		if (!instr.is_memory) begin
			rex   = xume_pkg::RexBase | xume_pkg::RexW | {7'd0, instr.reg_number[3]};
			modrm = {xume_pkg::ModDirect, instr.op_extension, instr.reg_number[2:0]};
			enc.bytes[0] = rex;
			enc.bytes[1] = xume_pkg::OpcUnary;
			enc.bytes[2] = modrm;
			enc.last_idx = xume_pkg::LastReg;
		end else begin
			rex   = xume_pkg::RexBase | xume_pkg::RexW |
				{6'd0, instr.has_index & instr.index_reg[3], instr.base_reg[3]};
			modrm = {mod_code, instr.op_extension,
				need_sib ? xume_pkg::RmSib : instr.base_reg[2:0]};
			enc.bytes[0] = rex;
			enc.bytes[1] = xume_pkg::OpcUnary;
			enc.bytes[2] = modrm;
			if (need_sib) begin
				enc.bytes[3] = sib;
				enc.bytes[4] = disp_b[0];
				enc.bytes[5] = disp_b[1];
				enc.bytes[6] = disp_b[2];
				enc.bytes[7] = disp_b[3];
			end else begin
				enc.bytes[3] = disp_b[0];
				enc.bytes[4] = disp_b[1];
				enc.bytes[5] = disp_b[2];
				enc.bytes[6] = disp_b[3];
			end
			enc.last_idx = (short_disp ? xume_pkg::LastShort : xume_pkg::LastLong) +
				{{(xume_pkg::IdxW-1){1'b0}}, need_sib};
		end
	end

endmodule
`default_nettype wire

### design/xume_serial.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// xume_serial
// Result register: holds one encoded instruction and sends it a byte a beat.
// -----------------------------------------------------------------------------
module xume_serial (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              enc_valid,
	input  xume_pkg::enc_t   enc,
	output logic             enc_take,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [7:0]       m_tdata,  // [7:0] code_byte
	output logic             m_tlast   // last_byte
);

	logic [xume_pkg::MaxBytes-1:0][7:0] bytes_q;
	logic [xume_pkg::IdxW-1:0]          last_q;
	logic [xume_pkg::IdxW-1:0]          pos_q;
	logic                               busy_q;
	logic                               at_last;
	logic                               beat;

	always_comb begin
		at_last  = (pos_q == last_q);
		beat     = busy_q && m_tready;
		enc_take = enc_valid && (!busy_q || (beat && at_last));
		m_tvalid = busy_q;
		m_tdata  = bytes_q[pos_q];
		m_tlast  = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (enc_take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (beat) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_take) begin
			bytes_q <= enc.bytes;
			last_q  <= enc.last_idx;
		end
	end

endmodule
`default_nettype wire

### design/xume_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// xume_checker
// Port-level checks on the encoded byte stream.
// -----------------------------------------------------------------------------
module xume_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [55:0] s_tdata,
	input wire        s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [7:0]  m_tdata,
	input wire        m_tlast
);

	logic [xume_pkg::IdxW-1:0] pos_q;
	logic                      beat;
	logic                      unused_in;

	assign beat      = m_tvalid && m_tready;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (beat) begin
			pos_q <= m_tlast ? '0 : pos_q + 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("byte changed while stalled");

	a_rex: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pos_q == '0 |-> m_tdata[7:3] == 5'b01001 && !m_tlast)
		else $error("first beat is not REX.W");

	a_opc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pos_q == xume_pkg::IdxW'(1) |-> m_tdata == xume_pkg::OpcUnary && !m_tlast)
		else $error("second beat is not the opcode");

	a_mod: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pos_q == xume_pkg::IdxW'(2) |->
			m_tlast == (m_tdata[7:6] == xume_pkg::ModDirect))
		else $error("instruction length does not match ModRM mode");

endmodule

bind x64_unary_modrm_encoder_core xume_checker u_xume_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
